>>> rtl/core/md5_pkg.sv
// Package for the MD5 engine: sequencer states, initial chaining values and
// the per-step constant tables (sine constants, rotations, message word order).
// Has no dependencies; used by md5_hash_engine_core.
package md5_pkg;

  // Sequencer states of the engine.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_FIN
  } md5_state_t;

  // Standard initial chaining values.
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  // Padding marker byte, the slots that hold the low and high length words, and the byte count of a full word.
  localparam logic [31:0] PAD_MARKER = 32'h00000080;
  localparam logic [3:0]  LEN_SLOT_LO = 4'd14;
  localparam logic [3:0]  LEN_SLOT_HI = 4'd15;
  localparam logic [2:0]  FULL_WORD   = 3'd4;

  // Sine-derived additive constant for each of the 64 steps.
  localparam logic [31:0] SINE_TAB [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Left rotation amount, indexed by round and by step within a group of four.
  localparam logic [4:0] ROT_TAB [4][4] = '{
    '{5'd7, 5'd12, 5'd17, 5'd22},
    '{5'd5, 5'd9,  5'd14, 5'd20},
    '{5'd4, 5'd11, 5'd16, 5'd23},
    '{5'd6, 5'd10, 5'd15, 5'd21}
  };

  // Message word order: first word and stride for each round.
  localparam logic [3:0] IDX_BEGIN [4] = '{4'd0, 4'd1, 4'd5, 4'd0};
  localparam logic [3:0] IDX_STEP  [4] = '{4'd1, 4'd5, 4'd3, 4'd7};

endpackage

>>> rtl/core/md5_hash_engine_core.sv
// MD5 digest engine. A word that does not fill a block is stored in the block
// buffer; a word that fills a block starts 64 round steps plus one add.
// A last word is followed by padding words in one or two blocks. The block
// buffer takes no new words while the one round unit does one step per cycle
// on a block, nor while the add is done.
// Reset (synchronous, active high) restores the initial vector and empties the block.
module md5_hash_engine_core
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_a,
  output logic [31:0] digest_b,
  output logic [31:0] digest_c,
  output logic [31:0] digest_d
);

  md5_state_t state, state_next;

  logic [31:0] chain_a, chain_b, chain_c, chain_d;
  logic [31:0] wa, wb, wc, wd;
  logic [31:0] block_words [16];
  logic [3:0]  word_position;
  logic [60:0] message_bytes;
  logic [5:0]  rnd;
  logic        padding, need_marker, len_phase, finishing;

  logic        accept;
  logic        push_en;
  logic [31:0] push_data;
  logic        wrap;
  logic        push_len_lo, push_len_hi;
  logic [2:0]  cnt_eff;
  logic [31:0] last_word;
  logic [63:0] bit_len;
  logic        fin_load;

  logic [1:0]  r;
  logic [3:0]  j;
  logic [3:0]  msg_idx;
  logic [31:0] f_val;
  logic [31:0] t_sum;
  logic [63:0] t_dbl;
  logic [31:0] t_rot;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign bit_len  = {message_bytes, 3'b000};
  assign fin_load = (state == ST_FIN) && (!out_valid || out_ready);

  // Effective byte count of the last word: anything above four counts as four.
  always_comb begin
    cnt_eff = (byte_count > FULL_WORD) ? FULL_WORD : byte_count;
    unique case (cnt_eff[1:0])
      2'd0:    last_word = PAD_MARKER;
      2'd1:    last_word = {16'h0000, PAD_MARKER[7:0], data_word[7:0]};
      2'd2:    last_word = {8'h00, PAD_MARKER[7:0], data_word[15:0]};
      default: last_word = {PAD_MARKER[7:0], data_word[23:0]};
    endcase
    if (cnt_eff == FULL_WORD) begin
      last_word = data_word;
    end
  end

  // Word written into the block buffer this cycle.
  always_comb begin
    push_en     = 1'b0;
    push_data   = data_word;
    push_len_lo = 1'b0;
    push_len_hi = 1'b0;
    if (state == ST_IDLE) begin
      push_en   = accept;
      push_data = last ? last_word : data_word;
    end else if (state == ST_PAD) begin
      push_en = 1'b1;
      priority if (need_marker) begin
        push_data = PAD_MARKER;
      end else if (word_position == LEN_SLOT_LO) begin
        push_data   = bit_len[31:0];
        push_len_lo = 1'b1;
      end else if (word_position == LEN_SLOT_HI && len_phase) begin
        push_data   = bit_len[63:32];
        push_len_hi = 1'b1;
      end else begin
        push_data = '0;
      end
    end
    wrap = push_en && (word_position == LEN_SLOT_HI);
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (wrap) state_next = ST_ROUND;
          else if (last) state_next = ST_PAD;
          else state_next = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (wrap) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (rnd == 6'd63) state_next = ST_ADD;
      end
      ST_ADD: begin
        priority if (finishing) state_next = ST_FIN;
        else if (padding) state_next = ST_PAD;
        else state_next = ST_IDLE;
      end
      ST_FIN: begin
        if (fin_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Shared round unit: one MD5 step per cycle.
  always_comb begin
    r = rnd[5:4];
    j = rnd[3:0];
    msg_idx = IDX_BEGIN[r] + IDX_STEP[r] * j;
    unique case (r)
      2'd0:    f_val = wd ^ (wb & (wc ^ wd));
      2'd1:    f_val = wc ^ (wd & (wb ^ wc));
      2'd2:    f_val = wb ^ wc ^ wd;
      default: f_val = wc ^ (wb | ~wd);
    endcase
    t_sum = wa + f_val + SINE_TAB[rnd] + block_words[msg_idx];
    t_dbl = {t_sum, t_sum} << ROT_TAB[r][j[1:0]];
    t_rot = t_dbl[63:32];
  end

  // Block buffer writes.
  always_ff @(posedge clk) begin
    if (push_en) begin
      block_words[word_position] <= push_data;
    end
  end

  // Working words, step counter and chaining words.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_a <= IV_A;
      chain_b <= IV_B;
      chain_c <= IV_C;
      chain_d <= IV_D;
      rnd     <= '0;
    end else begin
      if (wrap) begin
        wa  <= chain_a;
        wb  <= chain_b;
        wc  <= chain_c;
        wd  <= chain_d;
        rnd <= '0;
      end else if (state == ST_ROUND) begin
        wa  <= wd;
        wd  <= wc;
        wc  <= wb;
        wb  <= wb + t_rot;
        rnd <= rnd + 6'd1;
      end
      if (state == ST_ADD) begin
        chain_a <= chain_a + wa;
        chain_b <= chain_b + wb;
        chain_c <= chain_c + wc;
        chain_d <= chain_d + wd;
      end else if (fin_load) begin
        chain_a <= IV_A;
        chain_b <= IV_B;
        chain_c <= IV_C;
        chain_d <= IV_D;
      end
    end
  end

  // Message position, length count and padding flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_position <= '0;
      message_bytes <= '0;
      padding       <= 1'b0;
      need_marker   <= 1'b0;
      len_phase     <= 1'b0;
      finishing     <= 1'b0;
    end else begin
      if (push_en) begin
        word_position <= word_position + 4'd1;
      end
      if (accept) begin
        message_bytes <= message_bytes + (last ? 61'(cnt_eff) : 61'(FULL_WORD));
        if (last) begin
          padding     <= 1'b1;
          need_marker <= (cnt_eff == FULL_WORD);
        end
      end
      if (state == ST_PAD) begin
        if (need_marker) need_marker <= 1'b0;
        if (push_len_lo) len_phase <= 1'b1;
        if (push_len_hi) finishing <= 1'b1;
      end
      if (fin_load) begin
        word_position <= '0;
        message_bytes <= '0;
        padding       <= 1'b0;
        need_marker   <= 1'b0;
        len_phase     <= 1'b0;
        finishing     <= 1'b0;
      end
    end
  end

  // Digest output register; the next message may start while it waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      digest_a <= chain_a;
      digest_b <= chain_b;
      digest_c <= chain_c;
      digest_d <= chain_d;
    end
  end

endmodule
